// ===== rtl/lbdim_pkg.sv =====
// ----------------------------------------------------------------------------
// lbdim_pkg: shared definitions for the LED bridge dimmer
// Command and mode codes, register indexes, constants, the gamma curve and
// the command and status types between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lbdim_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_MODE   = 2'd1;
  localparam logic [1:0] CMD_BRIGHT = 2'd2;
  localparam logic [1:0] CMD_TOGGLE = 2'd3;

  // Bridge modes.
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_FWD = 2'd1;
  localparam logic [1:0] MODE_REV = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FADE_DUR = 2'd0;
  localparam logic [1:0] REG_PWM_WIN  = 2'd1;
  localparam logic [1:0] REG_BRT_MIN  = 2'd2;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [6:0]  PCT_MAX       = 7'd100;
  localparam logic [15:0] FADE_DUR_RST  = 16'd1000;
  localparam logic [7:0]  PWM_WIN_RST   = 8'd10;
  localparam logic [6:0]  BRT_MIN_RST   = 7'd20;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Quotient of the step division has five bits (curve has 32 points).
  localparam int          DIV_STEPS = 5;
  // x / 100 == (x * 5243) >> 19 exactly for x up to 25500.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic load;      // input transfer: apply command, start a tick
    logic div_step;  // one restoring-division step
    logic mul;       // delta times curve value
    logic scl;       // scale magnitude by 1/100
    logic lvl;       // update the level from the fade
    logic dmul;      // level times window
    logic dscl;      // scale duty by 1/100
    logic pwm;       // advance window phase and enable
    logic post;      // copy state into the output register
  } lbdim_cmd_t;

  typedef struct packed {
    logic div_last;
  } lbdim_stat_t;

  function automatic logic [6:0] gamma_lut(input logic [4:0] idx);
    logic [6:0] g;
    case (idx)
      5'd0:  g = 7'd0;   5'd1:  g = 7'd0;   5'd2:  g = 7'd0;   5'd3:  g = 7'd1;
      5'd4:  g = 7'd1;   5'd5:  g = 7'd2;   5'd6:  g = 7'd3;   5'd7:  g = 7'd4;
      5'd8:  g = 7'd5;   5'd9:  g = 7'd7;   5'd10: g = 7'd8;   5'd11: g = 7'd10;
      5'd12: g = 7'd12;  5'd13: g = 7'd15;  5'd14: g = 7'd17;  5'd15: g = 7'd20;
      5'd16: g = 7'd23;  5'd17: g = 7'd27;  5'd18: g = 7'd30;  5'd19: g = 7'd34;
      5'd20: g = 7'd38;  5'd21: g = 7'd42;  5'd22: g = 7'd47;  5'd23: g = 7'd52;
      5'd24: g = 7'd57;  5'd25: g = 7'd62;  5'd26: g = 7'd68;  5'd27: g = 7'd74;
      5'd28: g = 7'd80;  5'd29: g = 7'd86;  5'd30: g = 7'd93;  5'd31: g = 7'd100;
      default: g = 7'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lbdim_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbdim_ctrl: sequencing state machine
// Accepts one item at a time, steps the datapath through a tick and owns the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lbdim_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [1:0]          command,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output lbdim_pkg::lbdim_cmd_t    cmd,
  input  wire lbdim_pkg::lbdim_stat_t stat
);
  import lbdim_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_SCL  = 9'b000001000,
    S_LVL  = 9'b000010000,
    S_DMUL = 9'b000100000,
    S_DSCL = 9'b001000000,
    S_PWM  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    s_tready       = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (command == CMD_TICK) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SCL;
      end
      S_SCL: begin
        cmd.scl    = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: begin
        cmd.lvl    = 1'b1;
        state_next = S_DMUL;
      end
      S_DMUL: begin
        cmd.dmul   = 1'b1;
        state_next = S_DSCL;
      end
      S_DSCL: begin
        cmd.dscl   = 1'b1;
        state_next = S_PWM;
      end
      S_PWM: begin
        cmd.pwm    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          cmd.post       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/lbdim_dp.sv =====
// ----------------------------------------------------------------------------
// lbdim_dp: dimmer state and arithmetic
// Holds the configuration and dimmer state, the step divider, the two scaling
// multipliers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbdim_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lbdim_pkg::lbdim_cmd_t             cmd,
  output lbdim_pkg::lbdim_stat_t                 stat,
  input  wire logic                              cfg_we,
  input  wire logic [lbdim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbdim_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic [1:0]                        command,
  input  wire logic [1:0]                        mode_value,
  input  wire logic [7:0]                        brightness_value,
  output logic [lbdim_pkg::OUT_DATA_W-1:0]       res_data
);
  import lbdim_pkg::*;

  // Configuration.
  logic [15:0] fade_dur;
  logic [7:0]  pwm_win;
  logic [6:0]  brt_min;

  // Dimmer state.
  logic [1:0]  mode_reg,     mode_reg_next;
  logic [1:0]  pref_reg,     pref_reg_next;
  logic [6:0]  target_reg,   target_reg_next;
  logic [6:0]  level_reg,    level_reg_next;
  logic        fade_on,      fade_on_next;
  logic [15:0] fade_elapsed, fade_elapsed_next;
  logic [6:0]  fade_from,    fade_from_next;
  logic [6:0]  fade_to,      fade_to_next;
  logic [7:0]  phase,        phase_next;
  logic        enable_reg,   enable_reg_next;

  // Arithmetic pipeline registers.
  logic [20:0] rem;
  logic [4:0]  quot;
  logic [2:0]  div_cnt;
  logic        prod_neg;
  logic [13:0] prod_mag;
  logic [26:0] scl;
  logic [14:0] dprod;
  logic [27:0] dscl;

  function automatic logic [6:0] clamp_pct(input logic [7:0] v, input logic [6:0] lo);
    logic [7:0] t;
    t = (v < {1'b0, lo}) ? {1'b0, lo} : v;
    if (t > {1'b0, PCT_MAX}) begin
      t = {1'b0, PCT_MAX};
    end
    return t[6:0];
  endfunction

  logic [15:0] dur;
  logic [15:0] elapsed_inc;
  logic [20:0] div_trial;

  assign dur         = (fade_dur == '0) ? 16'd1 : fade_dur;
  assign elapsed_inc = (fade_elapsed != ELAPSED_MAX) ? fade_elapsed + 16'd1 : fade_elapsed;
  assign div_trial   = {5'b0, dur} << div_cnt;
  assign stat.div_last = (div_cnt == '0);

  // Command application and tick stages.
  always_comb begin
    logic [1:0]  mt;
    logic        chg;
    logic [6:0]  goal;
    logic [8:0]  fval;
    logic [8:0]  ph;
    logic [7:0]  qv;
    logic [8:0]  duty;

    mode_reg_next     = mode_reg;
    pref_reg_next     = pref_reg;
    target_reg_next   = target_reg;
    level_reg_next    = level_reg;
    fade_on_next      = fade_on;
    fade_elapsed_next = fade_elapsed;
    fade_from_next    = fade_from;
    fade_to_next      = fade_to;
    phase_next        = phase;
    enable_reg_next   = enable_reg;
    mt   = mode_value;
    chg  = 1'b0;
    goal = clamp_pct({1'b0, target_reg}, brt_min);
    qv   = scl[RECIP_SHIFT +: 8];
    fval = prod_neg ? {2'b0, fade_from} - {1'b0, qv} : {2'b0, fade_from} + {1'b0, qv};
    ph   = {1'b0, phase} + 9'd1;
    duty = dscl[RECIP_SHIFT +: 9];

    if (cmd.load) begin
      case (command)
        CMD_TICK: begin
          if (fade_on) begin
            fade_elapsed_next = elapsed_inc;
          end
        end
        CMD_MODE: begin
          chg = 1'b1;
        end
        CMD_BRIGHT: begin
          target_reg_next = clamp_pct(brightness_value, brt_min);
          fade_on_next    = 1'b0;
          if (mode_reg != MODE_OFF) begin
            level_reg_next = target_reg_next;
          end
        end
        CMD_TOGGLE: begin
          pref_reg_next = (pref_reg == MODE_FWD) ? MODE_REV : MODE_FWD;
          mt            = pref_reg_next;
          chg           = (mode_reg != MODE_OFF);
        end
        default: begin
          chg = 1'b0;
        end
      endcase

      if (chg && (mt <= MODE_REV) && (mt != mode_reg)) begin
        enable_reg_next = 1'b0;
        mode_reg_next   = mt;
        fade_on_next    = 1'b0;
        if (mode_reg == MODE_OFF) begin
          // Power on: start dark and fade toward the clamped target.
          level_reg_next    = '0;
          phase_next        = '0;
          fade_elapsed_next = '0;
          fade_from_next    = '0;
          fade_to_next      = goal;
          fade_on_next      = (goal != '0);
        end else if (mt == MODE_OFF) begin
          level_reg_next = '0;
        end
      end
    end

    if (cmd.lvl && fade_on) begin
      if (fade_elapsed >= dur) begin
        level_reg_next = fade_to;
        fade_on_next   = 1'b0;
      end else if (fval[8]) begin
        level_reg_next = '0;
      end else if (fval > {2'b0, PCT_MAX}) begin
        level_reg_next = PCT_MAX;
      end else begin
        level_reg_next = fval[6:0];
      end
    end

    if (cmd.pwm) begin
      if (mode_reg == MODE_OFF) begin
        enable_reg_next = 1'b0;
        phase_next      = '0;
      end else begin
        if (ph >= {1'b0, pwm_win}) begin
          ph = '0;
        end
        phase_next      = ph[7:0];
        enable_reg_next = ({1'b0, ph[7:0]} < duty);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_dur     <= FADE_DUR_RST;
      pwm_win      <= PWM_WIN_RST;
      brt_min      <= BRT_MIN_RST;
      mode_reg     <= MODE_OFF;
      pref_reg     <= MODE_FWD;
      target_reg   <= PCT_MAX;
      level_reg    <= PCT_MAX;
      fade_on      <= 1'b0;
      fade_elapsed <= '0;
      fade_from    <= '0;
      fade_to      <= '0;
      phase        <= '0;
      enable_reg   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FADE_DUR: fade_dur <= cfg_data;
          REG_PWM_WIN:  pwm_win  <= cfg_data[7:0];
          REG_BRT_MIN:  brt_min  <= cfg_data[6:0];
          default:      fade_dur <= fade_dur;
        endcase
      end
      mode_reg     <= mode_reg_next;
      pref_reg     <= pref_reg_next;
      target_reg   <= target_reg_next;
      level_reg    <= level_reg_next;
      fade_on      <= fade_on_next;
      fade_elapsed <= fade_elapsed_next;
      fade_from    <= fade_from_next;
      fade_to      <= fade_to_next;
      phase        <= phase_next;
      enable_reg   <= enable_reg_next;
    end
  end

  // Step division: incremented elapsed * 31 / duration, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.load) begin
      div_cnt <= 3'(DIV_STEPS - 1);
    end else if (cmd.div_step && !stat.div_last) begin
      div_cnt <= div_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= ({5'b0, elapsed_inc} << 5) - {5'b0, elapsed_inc};
      quot <= '0;
    end else if (cmd.div_step) begin
      if (rem >= div_trial) begin
        rem           <= rem - div_trial;
        quot[div_cnt] <= 1'b1;
      end
    end
  end

  // Fade and duty arithmetic, one multiplier per stage.
  always_ff @(posedge clk) begin
    logic signed [7:0]  delta;
    logic signed [15:0] prod;
    logic [15:0]        pabs;
    delta = $signed({1'b0, fade_to}) - $signed({1'b0, fade_from});
    prod  = delta * $signed({1'b0, gamma_lut(quot)});
    pabs  = prod[15] ? 16'(-prod) : 16'(prod);
    if (cmd.mul) begin
      prod_neg <= prod[15];
      prod_mag <= pabs[13:0];
    end
    if (cmd.scl) begin
      scl <= {13'b0, prod_mag} * {14'b0, RECIP_100};
    end
    if (cmd.dmul) begin
      dprod <= {8'b0, level_reg} * {7'b0, pwm_win};
    end
    if (cmd.dscl) begin
      dscl <= {13'b0, dprod} * {15'b0, RECIP_100};
    end
  end

  // Output register: the result of the item just finished.
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      res_data <= {2'b0, pref_reg, target_reg, mode_reg, level_reg, enable_reg,
                   (mode_reg != MODE_OFF), (mode_reg == MODE_REV), (mode_reg == MODE_FWD)};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/led_bridge_dimmer_with_gamma_fade.sv =====
// A tick passes through the step divider, the fade multiply and scale, the level
// update, the duty multiply and scale and the phase step before its result is posted;
// other commands are posted directly. Posting waits while an unread result is held,
// but a new item is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) restores every state and configuration
// register to its reset value at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// led_bridge_dimmer_with_gamma_fade: two-direction LED bridge dimmer
// Takes tick, set mode, set brightness and toggle direction commands and
// returns the bridge pin levels and dimmer status for each command.
// ----------------------------------------------------------------------------
`default_nettype none

module led_bridge_dimmer_with_gamma_fade (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata: mode_value[1:0], brightness_value[9:2], zero fill above.
  input  wire logic [lbdim_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: command[1:0].
  input  wire logic [1:0]                         s_tuser,
  // Result stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata: leg_one[0], leg_two[1], bridge_awake[2], drive_enable[3],
  // level_pct[10:4], mode_now[12:11], user_target[19:13], preferred_now[21:20].
  output logic [lbdim_pkg::OUT_DATA_W-1:0]        m_tdata,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [lbdim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lbdim_pkg::CFG_W-1:0]        cfg_data
);
  import lbdim_pkg::*;

  // The controller sequences each item; the datapath holds the state and
  // does all arithmetic. A tick walks through the divider, the fade scaling
  // and the duty scaling before its result is posted.
  lbdim_cmd_t  cmd;
  lbdim_stat_t stat;

  lbdim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath applies the command on the input transfer itself, so the
  // payload fields only need to be valid at that edge.
  lbdim_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .command          (s_tuser),
    .mode_value       (s_tdata[1:0]),
    .brightness_value (s_tdata[9:2]),
    .res_data         (m_tdata)
  );

`ifndef SYNTH
  // Only one item is in flight: the input is closed in the cycle after a transfer in.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item was in flight");

  // Pin and status fields of a result agree with its mode.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[2] == (m_tdata[12:11] != MODE_OFF)) &&
                  (m_tdata[0] == (m_tdata[12:11] == MODE_FWD)) &&
                  (m_tdata[1] == (m_tdata[12:11] == MODE_REV))))
    else $error("bridge pins disagree with mode");

  // The driver is never enabled with the bridge off, and levels stay in range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!(m_tdata[3] && (m_tdata[12:11] == MODE_OFF)) &&
                  (m_tdata[10:4] <= PCT_MAX) && (m_tdata[19:13] <= PCT_MAX)))
    else $error("enable or percent out of range");
`endif

endmodule

`default_nettype wire
